>>> sv/trs_pkg.sv
// ============================================================================
// trs_pkg
// Types and constants shared by the TRS matrix pipeline.
// ============================================================================
package trs_pkg;

    localparam int WD         = 32;        // port word width
    localparam int CW         = 34;        // Q30 cos/sin/quaternion/rotation width
    localparam int ZW         = 27;        // CORDIC angle accumulator width
    localparam int PW         = 66;        // Q60 product width
    localparam int STEPS      = 20;
    localparam int NS         = 33;        // pipeline stages

    localparam logic [33:0] ANG_OFFSET   = 34'd2170552320;  // 92 full turns
    localparam logic [16:0] RECIP_360    = 17'd93207;       // ceil(2^25 / 360)
    localparam int          RECIP_SHIFT  = 25;
    localparam logic [8:0]  DEG_360      = 9'd360;
    localparam logic [24:0] FULL_TURN    = 25'd23592960;
    localparam logic [24:0] QUARTER_HALF = 25'd11796480;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [PW-1:0] ONE_Q60     = 66'sd1 <<< 60;

    typedef logic signed [WD-1:0] t_word;
    typedef logic signed [CW-1:0] t_q30;
    typedef logic signed [PW-1:0] t_q60;
    typedef logic signed [ZW-1:0] t_ang;

    localparam t_ang ATAN_TAB [STEPS] = '{
        27'sd5898240, 27'sd3481934, 27'sd1839759, 27'sd933892, 27'sd468757,
        27'sd234607,  27'sd117332,  27'sd58670,   27'sd29335,  27'sd14668,
        27'sd7334,    27'sd3667,    27'sd1833,    27'sd917,    27'sd458,
        27'sd229,     27'sd115,     27'sd57,      27'sd29,     27'sd14
    };

    // add half an LSB then floor, Q60 -> Q30
    function automatic t_q60 rnd30(input t_q60 v);
        t_q60 t;
        t = v + (66'sd1 <<< 29);
        return t >>> 30;
    endfunction

    function automatic t_word sat32(input t_q60 v);
        t_word r;
        if (v > 66'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[WD-1:0];
        end
        return r;
    endfunction

endpackage

>>> sv/trs_transform_matrix.sv
// ============================================================================
// trs_transform_matrix
// Top three rows of translate*rotate*scale from Euler angles, Q16.16.
// ============================================================================
//  channel | valid      | ready       | data
//  in      | i_in_valid | o_in_ready  | i_pos_*, i_angle_*_deg, i_scale_*
//  out     | o_out_valid| i_out_ready | o_rRcC
//
//  33-stage pipeline, one word per cycle while i_out_ready does not stall it.
//  Stages: angle mod 360 (3), fold, 20 CORDIC steps, sign restore,
//  quaternion (4), matrix (2), scale (2). Each stage holds a valid bit.
//  A stage advances when empty or when the stage after it advances, so
//  bubbles collapse and a stalled output does not block upstream fill.
//  Synchronous active-low reset clears the valid bits only.
// ============================================================================
module trs_transform_matrix (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  logic [31:0]  i_pos_x,
    input  logic [31:0]  i_pos_y,
    input  logic [31:0]  i_pos_z,
    input  logic [31:0]  i_angle_x_deg,
    input  logic [31:0]  i_angle_y_deg,
    input  logic [31:0]  i_angle_z_deg,
    input  logic [31:0]  i_scale_x,
    input  logic [31:0]  i_scale_y,
    input  logic [31:0]  i_scale_z,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output logic [31:0]  o_r0c0,
    output logic [31:0]  o_r0c1,
    output logic [31:0]  o_r0c2,
    output logic [31:0]  o_r0c3,
    output logic [31:0]  o_r1c0,
    output logic [31:0]  o_r1c1,
    output logic [31:0]  o_r1c2,
    output logic [31:0]  o_r1c3,
    output logic [31:0]  o_r2c0,
    output logic [31:0]  o_r2c1,
    output logic [31:0]  o_r2c2,
    output logic [31:0]  o_r2c3
);

    localparam int NS    = trs_pkg::NS;
    localparam int STEPS = trs_pkg::STEPS;
    localparam int RECIP_SHIFT_HI = trs_pkg::RECIP_SHIFT + 7;

    logic [NS-1:0] r_vld;
    logic [NS:0]   w_en;

    trs_pkg::t_word r_pos [NS][3];
    trs_pkg::t_word r_scl [NS][3];

    // angle reduction
    logic [16:0] r_u  [3];
    logic [15:0] r_lo0 [3];
    logic [7:0]  r_q  [3];
    logic [16:0] r_u1 [3];
    logic [15:0] r_lo1 [3];
    logic [8:0]  r_r  [3];
    logic [15:0] r_lo2 [3];

    // CORDIC taps
    trs_pkg::t_q30 r_cx [STEPS+1][3];
    trs_pkg::t_q30 r_cy [STEPS+1][3];
    trs_pkg::t_ang r_cz [STEPS+1][3];
    logic          r_cn [STEPS+1][3];

    trs_pkg::t_q30 r_c [3];
    trs_pkg::t_q30 r_s [3];

    trs_pkg::t_q60 r_p4 [4];
    trs_pkg::t_q30 r_cz1, r_sz1, r_cz2, r_sz2;
    trs_pkg::t_q30 r_ccy, r_scy, r_csy, r_ssy;
    trs_pkg::t_q60 r_p8 [8];
    trs_pkg::t_q30 r_qw, r_qx, r_qy, r_qz;
    trs_pkg::t_q60 r_p9 [9];
    trs_pkg::t_q30 r_rot [3][3];
    trs_pkg::t_q60 r_prs [3][3];
    trs_pkg::t_word r_out [3][3];

    logic [33:0] n_v [3];
    logic [32:0] n_qm [3];
    logic [16:0] n_r0 [3];
    logic [24:0] n_h [3];
    trs_pkg::t_word w_ang [3];
    trs_pkg::t_word w_pos [3];
    trs_pkg::t_word w_scl [3];

    function automatic trs_pkg::t_q60 mul(input trs_pkg::t_q30 a, input trs_pkg::t_q30 b);
        logic signed [2*trs_pkg::CW-1:0] p;
        p = a * b;
        return p[trs_pkg::PW-1:0];
    endfunction

    // Q30 rotation entry times Q16.16 scale
    function automatic trs_pkg::t_q60 smul(input trs_pkg::t_q30 a, input trs_pkg::t_word b);
        trs_pkg::t_q60 p;
        p = a * b;
        return p;
    endfunction

    function automatic trs_pkg::t_q30 rq(input trs_pkg::t_q60 v);
        trs_pkg::t_q60 t;
        t = trs_pkg::rnd30(v);
        return t[trs_pkg::CW-1:0];
    endfunction

    assign w_ang = '{i_angle_x_deg, i_angle_y_deg, i_angle_z_deg};
    assign w_pos = '{i_pos_x, i_pos_y, i_pos_z};
    assign w_scl = '{i_scale_x, i_scale_y, i_scale_z};

    always_comb begin
        w_en[NS] = i_out_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_v[a]  = {{2{w_ang[a][31]}}, w_ang[a]} + trs_pkg::ANG_OFFSET;
            n_qm[a] = {16'd0, r_u[a]} * {16'd0, trs_pkg::RECIP_360};
            n_r0[a] = r_u1[a] - ({9'd0, r_q[a]} * {8'd0, trs_pkg::DEG_360});
            n_h[a]  = 25'({16'd0, r_r[a]} << 16) | {9'd0, r_lo2[a]};
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // side band
        if (w_en[0]) begin
            r_pos[0] <= w_pos;
            r_scl[0] <= w_scl;
        end
        for (int k = 1; k < NS; k++) begin
            if (w_en[k]) begin
                r_pos[k] <= r_pos[k-1];
                r_scl[k] <= r_scl[k-1];
            end
        end

        for (int a = 0; a < 3; a++) begin
            // mod 360 on the integer degrees
            if (w_en[0]) begin
                r_u[a]   <= n_v[a][32:16];
                r_lo0[a] <= n_v[a][15:0];
            end
            if (w_en[1]) begin
                r_q[a]   <= n_qm[a][RECIP_SHIFT_HI:trs_pkg::RECIP_SHIFT];
                r_u1[a]  <= r_u[a];
                r_lo1[a] <= r_lo0[a];
            end
            if (w_en[2]) begin
                r_r[a]   <= (n_r0[a] >= 17'(trs_pkg::DEG_360))
                            ? 9'(n_r0[a] - 17'(trs_pkg::DEG_360)) : n_r0[a][8:0];
                r_lo2[a] <= r_lo1[a];
            end
            // fold half angle into [-90, 90)
            if (w_en[3]) begin
                r_cx[0][a] <= trs_pkg::CORDIC_GAIN;
                r_cy[0][a] <= '0;
                if (n_h[a] >= trs_pkg::QUARTER_HALF) begin
                    r_cz[0][a] <= trs_pkg::t_ang'({2'b00, n_h[a]})
                                - trs_pkg::t_ang'({2'b00, trs_pkg::FULL_TURN});
                    r_cn[0][a] <= 1'b1;
                end else begin
                    r_cz[0][a] <= trs_pkg::t_ang'({2'b00, n_h[a]});
                    r_cn[0][a] <= 1'b0;
                end
            end
            for (int i = 0; i < STEPS; i++) begin
                if (w_en[4+i]) begin
                    r_cn[i+1][a] <= r_cn[i][a];
                    if (!r_cz[i][a][trs_pkg::ZW-1]) begin
                        r_cx[i+1][a] <= r_cx[i][a] - (r_cy[i][a] >>> i);
                        r_cy[i+1][a] <= r_cy[i][a] + (r_cx[i][a] >>> i);
                        r_cz[i+1][a] <= r_cz[i][a] - trs_pkg::ATAN_TAB[i];
                    end else begin
                        r_cx[i+1][a] <= r_cx[i][a] + (r_cy[i][a] >>> i);
                        r_cy[i+1][a] <= r_cy[i][a] - (r_cx[i][a] >>> i);
                        r_cz[i+1][a] <= r_cz[i][a] + trs_pkg::ATAN_TAB[i];
                    end
                end
            end
            if (w_en[24]) begin
                r_c[a] <= r_cn[STEPS][a] ? -r_cx[STEPS][a] : r_cx[STEPS][a];
                r_s[a] <= r_cn[STEPS][a] ? -r_cy[STEPS][a] : r_cy[STEPS][a];
            end
        end

        // quaternion qx * qy * qz
        if (w_en[25]) begin
            r_p4[0] <= mul(r_c[0], r_c[1]);
            r_p4[1] <= mul(r_s[0], r_c[1]);
            r_p4[2] <= mul(r_c[0], r_s[1]);
            r_p4[3] <= mul(r_s[0], r_s[1]);
            r_cz1   <= r_c[2];
            r_sz1   <= r_s[2];
        end
        if (w_en[26]) begin
            r_ccy <= rq(r_p4[0]);
            r_scy <= rq(r_p4[1]);
            r_csy <= rq(r_p4[2]);
            r_ssy <= rq(r_p4[3]);
            r_cz2 <= r_cz1;
            r_sz2 <= r_sz1;
        end
        if (w_en[27]) begin
            r_p8[0] <= mul(r_ccy, r_cz2);
            r_p8[1] <= mul(r_ssy, r_sz2);
            r_p8[2] <= mul(r_scy, r_cz2);
            r_p8[3] <= mul(r_csy, r_sz2);
            r_p8[4] <= mul(r_csy, r_cz2);
            r_p8[5] <= mul(r_scy, r_sz2);
            r_p8[6] <= mul(r_ccy, r_sz2);
            r_p8[7] <= mul(r_ssy, r_cz2);
        end
        if (w_en[28]) begin
            r_qw <= rq(r_p8[0] - r_p8[1]);
            r_qx <= rq(r_p8[2] + r_p8[3]);
            r_qy <= rq(r_p8[4] - r_p8[5]);
            r_qz <= rq(r_p8[6] + r_p8[7]);
        end
        // rotation matrix
        if (w_en[29]) begin
            r_p9[0] <= mul(r_qx, r_qx);
            r_p9[1] <= mul(r_qy, r_qy);
            r_p9[2] <= mul(r_qz, r_qz);
            r_p9[3] <= mul(r_qx, r_qy);
            r_p9[4] <= mul(r_qx, r_qz);
            r_p9[5] <= mul(r_qy, r_qz);
            r_p9[6] <= mul(r_qw, r_qx);
            r_p9[7] <= mul(r_qw, r_qy);
            r_p9[8] <= mul(r_qw, r_qz);
        end
        if (w_en[30]) begin
            r_rot[0][0] <= rq(trs_pkg::ONE_Q60 - ((r_p9[1] + r_p9[2]) <<< 1));
            r_rot[0][1] <= rq((r_p9[3] - r_p9[8]) <<< 1);
            r_rot[0][2] <= rq((r_p9[4] + r_p9[7]) <<< 1);
            r_rot[1][0] <= rq((r_p9[3] + r_p9[8]) <<< 1);
            r_rot[1][1] <= rq(trs_pkg::ONE_Q60 - ((r_p9[0] + r_p9[2]) <<< 1));
            r_rot[1][2] <= rq((r_p9[5] - r_p9[6]) <<< 1);
            r_rot[2][0] <= rq((r_p9[4] - r_p9[7]) <<< 1);
            r_rot[2][1] <= rq((r_p9[5] + r_p9[6]) <<< 1);
            r_rot[2][2] <= rq(trs_pkg::ONE_Q60 - ((r_p9[0] + r_p9[1]) <<< 1));
        end
        // column scale
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (w_en[31]) begin
                    r_prs[r][c] <= smul(r_rot[r][c], r_scl[30][c]);
                end
                if (w_en[32]) begin
                    r_out[r][c] <= trs_pkg::sat32(trs_pkg::rnd30(r_prs[r][c]));
                end
            end
        end
    end

    assign o_r0c0 = r_out[0][0];
    assign o_r0c1 = r_out[0][1];
    assign o_r0c2 = r_out[0][2];
    assign o_r0c3 = r_pos[NS-1][0];
    assign o_r1c0 = r_out[1][0];
    assign o_r1c1 = r_out[1][1];
    assign o_r1c2 = r_out[1][2];
    assign o_r1c3 = r_pos[NS-1][1];
    assign o_r2c0 = r_out[2][0];
    assign o_r2c1 = r_out[2][1];
    assign o_r2c2 = r_out[2][2];
    assign o_r2c3 = r_pos[NS-1][2];

`ifndef SYNTH
    a_ready_when_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> o_in_ready)
        else $error("input stalled while output drains");
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output stage");
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
    a_fold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (r_r[0] < trs_pkg::DEG_360))
        else $error("angle reduction out of range");
`endif

endmodule

>>> dv/tb_trs_transform_matrix.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_trs_transform_matrix
// Self-checking bench: fixed-point TRS predictor against the pipelined block.
// Directed corner words, then random words under three idle/stall profiles.
// ============================================================================
module tb_trs_transform_matrix;

    typedef struct {
        logic [31:0] f[12];
    } t_matrix;

    class trs_scoreboard;
        t_matrix pending[$];
        int      errors;

        function longint round30(longint v, int s);
            return (v + (longint'(1) <<< (s - 1))) >>> s;
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647) begin
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648) begin
                return -64'sd2147483648;
            end
            return v;
        endfunction

        function void half_angle(logic [31:0] code, output longint c,
                                 output longint s);
            longint h, x, y, z, dx, dy;
            longint tab[20] = '{5898240, 3481934, 1839759, 933892, 468757,
                234607, 117332, 58670, 29335, 14668, 7334, 3667, 1833, 917,
                458, 229, 115, 57, 29, 14};
            bit flip;
            h = longint'($signed(code)) % 64'sd23592960;
            if (h < 0) begin
                h += 23592960;
            end
            flip = 0;
            if (h >= 11796480) begin
                h -= 23592960;
                flip = 1;
            end
            x = 652032874;
            y = 0;
            z = h;
            for (int i = 0; i < 20; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= tab[i];
                end else begin
                    x += dx; y -= dy; z += tab[i];
                end
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function void note_input(logic [31:0] w[9]);
            longint cx, sx, cy, sy, cz, sz, ccy, scy, csy, ssy;
            longint qw, qx, qy, qz, one, v;
            longint rot[3][3];
            t_matrix m;
            half_angle(w[3], cx, sx);
            half_angle(w[4], cy, sy);
            half_angle(w[5], cz, sz);
            ccy = round30(cx * cy, 30);
            scy = round30(sx * cy, 30);
            csy = round30(cx * sy, 30);
            ssy = round30(sx * sy, 30);
            qw = round30(ccy * cz - ssy * sz, 30);
            qx = round30(scy * cz + csy * sz, 30);
            qy = round30(csy * cz - scy * sz, 30);
            qz = round30(ccy * sz + ssy * cz, 30);
            one = longint'(1) <<< 60;
            rot[0][0] = round30(one - 2 * (qy * qy + qz * qz), 30);
            rot[0][1] = round30(2 * (qx * qy - qw * qz), 30);
            rot[0][2] = round30(2 * (qx * qz + qw * qy), 30);
            rot[1][0] = round30(2 * (qx * qy + qw * qz), 30);
            rot[1][1] = round30(one - 2 * (qx * qx + qz * qz), 30);
            rot[1][2] = round30(2 * (qy * qz - qw * qx), 30);
            rot[2][0] = round30(2 * (qx * qz - qw * qy), 30);
            rot[2][1] = round30(2 * (qy * qz + qw * qx), 30);
            rot[2][2] = round30(one - 2 * (qx * qx + qy * qy), 30);
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    v = clamp32(round30(rot[r][c] *
                        longint'($signed(w[6 + c])), 30));
                    m.f[r * 4 + c] = v[31:0];
                end
                m.f[r * 4 + 3] = w[r];
            end
            pending.push_back(m);
        endfunction

        function void check_result(logic [31:0] got[12]);
            t_matrix m;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual r0c0=%h",
                         $time, got[0]);
                errors++;
                return;
            end
            m = pending.pop_front();
            for (int i = 0; i < 12; i++) begin
                if (m.f[i] !== got[i]) begin
                    $display("%0t: r%0dc%0d mismatch expected %h actual %h",
                             $time, i / 4, i % 4, m.f[i], got[i]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_in_valid = 0;
    logic        o_in_ready;
    logic [31:0] w_in[9] = '{default: '0};
    logic        o_out_valid;
    logic        i_out_ready = 0;
    logic [31:0] o_r[12];

    int          send_idle = 36;
    int          recv_idle = 56;
    int          stall_cycles = 0;
    bit          timed_out = 0;
    trs_scoreboard board = new();

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    trs_transform_matrix dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_pos_x(w_in[0]), .i_pos_y(w_in[1]), .i_pos_z(w_in[2]),
        .i_angle_x_deg(w_in[3]), .i_angle_y_deg(w_in[4]), .i_angle_z_deg(w_in[5]),
        .i_scale_x(w_in[6]), .i_scale_y(w_in[7]), .i_scale_z(w_in[8]),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_r0c0(o_r[0]), .o_r0c1(o_r[1]), .o_r0c2(o_r[2]), .o_r0c3(o_r[3]),
        .o_r1c0(o_r[4]), .o_r1c1(o_r[5]), .o_r1c2(o_r[6]), .o_r1c3(o_r[7]),
        .o_r2c0(o_r[8]), .o_r2c1(o_r[9]), .o_r2c2(o_r[10]), .o_r2c3(o_r[11])
    );

    // receiver side: check on handshake, re-roll ready every cycle
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                board.check_result(o_r);
            end
            i_out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles > 5000 && !timed_out) begin
            timed_out = 1;
            $display("trs_transform_matrix regression: fail");
            $finish;
        end
    end

    function automatic logic [31:0] pick_field(int k);
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0001_0000;
            3: return (k >= 6) ? 32'hffff_0000 : 32'h0;
            4: return $urandom_range(360) << 16;
            5: return (k >= 6) ? $urandom_range(262143) - 131072 : $urandom;
            default: return $urandom;
        endcase
    endfunction

    // valid stays high across back-to-back words; dropped only while idling
    task automatic send_word(logic [31:0] w[9]);
        if ($urandom_range(99) < send_idle) begin
            i_in_valid <= 0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle) begin
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1;
        for (int i = 0; i < 9; i++) begin
            w_in[i] <= w[i];
        end
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        board.note_input(w);
    endtask

    task automatic send_random(int n);
        logic [31:0] w[9];
        for (int j = 0; j < n; j++) begin
            for (int k = 0; k < 9; k++) begin
                w[k] = pick_field(k);
            end
            send_word(w);
        end
    endtask

    initial begin
        logic [31:0] w[9];
        logic [31:0] angles[10];
        angles = '{32'h0, 32'h005a_0000, 32'h00b4_0000,
            32'h010e_0000, 32'h0168_0000, 32'hffa6_0000, 32'h8000_0000,
            32'h7fff_ffff, 32'hffff_ffff, 32'h0000_0001};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: exact quarter-turn angles, wrap points, extreme scales
        for (int j = 0; j < 10; j++) begin
            for (int k = 0; k < 9; k++) begin
                w[k] = (k >= 6) ? 32'h0001_0000 : 32'h0;
            end
            w[3 + j % 3] = angles[j];
            w[3 + (j + 1) % 3] = angles[9 - j];
            send_word(w);
        end
        for (int j = 0; j < 8; j++) begin
            for (int k = 0; k < 9; k++) begin
                w[k] = j[0] ? 32'h7fff_ffff : 32'h8000_0000;
            end
            w[3] = angles[j];
            w[6 + j % 3] = j[1] ? 32'hffff_ffff : 32'h0;
            send_word(w);
        end
        send_random(380);
        send_idle = 56;
        recv_idle = 36;
        send_random(380);
        send_idle = 0;
        recv_idle = 0;
        send_random(380);
        i_in_valid <= 0;
        while (board.pending.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("trs_transform_matrix regression: pass");
        end else begin
            $display("trs_transform_matrix regression: fail");
        end
        $finish;
    end

endmodule
